// ===== src/cca_pkg.sv =====
`timescale 1ns / 1ps

package cca_pkg;

	// Cube geometry
	localparam int CUBE_DIM    = 3;
	localparam int NUM_CORNERS = 1 << CUBE_DIM;
	localparam int FACET_CNT   = 2 * CUBE_DIM;
	// Regions: every facet, then the whole cube
	localparam int NUM_REGIONS = FACET_CNT + 1;
	localparam int WHOLE_IDX   = FACET_CNT;

	// Port widths
	localparam int PATTERN_W = 8;
	localparam int FACETS_W  = 6;
	localparam int COUNT_W   = 3;

	// Internal widths that cover both the geometry and the port fields
	localparam int PAT_EXT_W  = (NUM_CORNERS > PATTERN_W) ? NUM_CORNERS : PATTERN_W;
	localparam int MASK_EXT_W = (FACET_CNT > FACETS_W) ? FACET_CNT : FACETS_W;
	localparam int CNT_BITS   = $clog2(FACET_CNT + 1);
	localparam int CNT_EXT_W  = (CNT_BITS > COUNT_W) ? CNT_BITS : COUNT_W;

	// A shortest path inside a component never exceeds corners - 1 edges
	localparam int FLOOD_STEPS     = NUM_CORNERS - 1;
	localparam int FLOOD_STAGES    = 2;
	localparam int STEPS_PER_STAGE = (FLOOD_STEPS + FLOOD_STAGES - 1) / FLOOD_STAGES;

	typedef logic [NUM_CORNERS-1:0] corners_t;

	// Per-region flood state: allowed sets of each sign and what is reached so far
	typedef struct packed {
		corners_t pos;
		corners_t neg;
		corners_t pos_reach;
		corners_t neg_reach;
	} region_t;

	typedef region_t [NUM_REGIONS-1:0] regions_t;

	// Corners of region r: facet r holds coordinate (r mod D) == (r div D)
	function automatic corners_t region_mask(input int r);
		corners_t m;
		int       axis;
		int       side;
		m    = '0;
		axis = r % CUBE_DIM;
		side = r / CUBE_DIM;
		for (int v = 0; v < NUM_CORNERS; v++) begin
			if (r == WHOLE_IDX) begin
				m[v] = 1'b1;
			end else begin
				m[v] = (((v >> axis) & 1) == side);
			end
		end
		return m;
	endfunction

	// One step of flood fill along cube edges inside the allowed set
	function automatic corners_t flood_step(input corners_t reach, input corners_t allowed);
		corners_t nxt;
		nxt = reach;
		for (int v = 0; v < NUM_CORNERS; v++) begin
			for (int d = 0; d < CUBE_DIM; d++) begin
				if (reach[v] && allowed[v ^ (1 << d)]) begin
					nxt[v ^ (1 << d)] = 1'b1;
				end
			end
		end
		return nxt;
	endfunction

endpackage

// ===== src/cube_config_ambiguity_check.sv =====
`timescale 1ns / 1ps

// Ambiguity check for one cube sign pattern. A pattern is taken on every clock
// in which start is high (busy never rises), and its result shows on the
// outputs, marked by done, for exactly one cycle; the receiver must take it
// then. The pattern passes through the seed stage, two flood-fill stages and
// the compare/count stage, each registered. Throughput is one transaction per
// clock. No state survives between patterns and no initialization pass
// follows reset.
module cube_config_ambiguity_check import cca_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [PATTERN_W-1:0] sign_pattern,
	output logic                 done,
	output logic                 config_ambiguous,
	output logic [FACETS_W-1:0]  ambiguous_facets,
	output logic [COUNT_W-1:0]   ambiguous_facet_count
);

	logic     valid_s1;
	regions_t regions_s1;
	logic     valid_s2;
	regions_t regions_s2;
	logic     valid_s3;
	regions_t regions_s3;

	// Fully pipelined, never stalls
	assign busy = 1'b0;

	// Seed
	cca_seed u_seed (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (start && !busy),
		.sign_pattern (sign_pattern),
		.valid_s1     (valid_s1),
		.regions_s1   (regions_s1)
	);

	// First half of flood fill
	cca_flood u_flood_a (
		.clk         (clk),
		.arst_n      (arst_n),
		.valid_in    (valid_s1),
		.regions_in  (regions_s1),
		.valid_out   (valid_s2),
		.regions_out (regions_s2)
	);

	// Second half of flood fill
	cca_flood u_flood_b (
		.clk         (clk),
		.arst_n      (arst_n),
		.valid_in    (valid_s2),
		.regions_in  (regions_s2),
		.valid_out   (valid_s3),
		.regions_out (regions_s3)
	);

	// Compare and count
	cca_judge u_judge (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid_in     (valid_s3),
		.regions_in   (regions_s3),
		.done_s4      (done),
		.whole_amb_s4 (config_ambiguous),
		.facets_s4    (ambiguous_facets),
		.count_s4     (ambiguous_facet_count)
	);

`ifndef SYNTHESIS
	// Every accepted pattern yields a result
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##4 done)
		else $error("result missing four cycles after accepted pattern");

	// No result without a matching accepted pattern
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 4))
		else $error("result without matching transaction");

	// Count agrees with the facet mask
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (ambiguous_facet_count == COUNT_W'($countones(ambiguous_facets))))
		else $error("facet count disagrees with facet mask");

	// An all-zero pattern is never ambiguous
	a_uniform: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && sign_pattern == '0) |->
		##4 (done && !config_ambiguous && ambiguous_facets == '0))
		else $error("uniform pattern reported ambiguous");
`endif

endmodule

// ===== src/cca_seed.sv =====
`timescale 1ns / 1ps

module cca_seed import cca_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [PATTERN_W-1:0] sign_pattern,
	output logic                 valid_s1,
	output regions_t             regions_s1
);

	logic [PAT_EXT_W-1:0] pat_ext;
	corners_t             ones;
	regions_t             regions_d;

	// Bits beyond the corner count are dropped, missing corners read as 0
	assign pat_ext = PAT_EXT_W'(sign_pattern);
	assign ones    = pat_ext[NUM_CORNERS-1:0];

	// Split each region by sign and seed both floods at the lowest corner
	always_comb begin
		for (int r = 0; r < NUM_REGIONS; r++) begin
			regions_d[r].pos       = ones & region_mask(r);
			regions_d[r].neg       = ~ones & region_mask(r);
			regions_d[r].pos_reach = regions_d[r].pos & (~regions_d[r].pos + corners_t'(1));
			regions_d[r].neg_reach = regions_d[r].neg & (~regions_d[r].neg + corners_t'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		regions_s1 <= regions_d;
	end

endmodule

// ===== src/cca_flood.sv =====
`timescale 1ns / 1ps

module cca_flood import cca_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     valid_in,
	input  regions_t regions_in,
	output logic     valid_out,
	output regions_t regions_out
);

	regions_t grown;

	// STEPS_PER_STAGE flood steps for all regions side by side
	always_comb begin
		grown = regions_in;
		for (int r = 0; r < NUM_REGIONS; r++) begin
			for (int s = 0; s < STEPS_PER_STAGE; s++) begin
				grown[r].pos_reach = flood_step(grown[r].pos_reach, grown[r].pos);
				grown[r].neg_reach = flood_step(grown[r].neg_reach, grown[r].neg);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else begin
			valid_out <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		regions_out <= grown;
	end

endmodule

// ===== src/cca_judge.sv =====
`timescale 1ns / 1ps

module cca_judge import cca_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid_in,
	input  regions_t            regions_in,
	output logic                done_s4,
	output logic                whole_amb_s4,
	output logic [FACETS_W-1:0] facets_s4,
	output logic [COUNT_W-1:0]  count_s4
);

	logic [NUM_REGIONS-1:0] amb;
	logic [MASK_EXT_W-1:0]  facet_ext;
	logic [CNT_EXT_W-1:0]   cnt;

	// A region is ambiguous when a flood missed part of its own sign
	always_comb begin
		for (int r = 0; r < NUM_REGIONS; r++) begin
			amb[r] = (regions_in[r].pos_reach != regions_in[r].pos) ||
			         (regions_in[r].neg_reach != regions_in[r].neg);
		end
	end

	// Facet mask and its population count
	always_comb begin
		facet_ext = MASK_EXT_W'(amb[FACET_CNT-1:0]);
		cnt       = '0;
		for (int f = 0; f < FACET_CNT; f++) begin
			cnt = cnt + CNT_EXT_W'(amb[f]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s4 <= 1'b0;
		end else begin
			done_s4 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		whole_amb_s4 <= amb[WHOLE_IDX];
		facets_s4    <= facet_ext[FACETS_W-1:0];
		count_s4     <= cnt[COUNT_W-1:0];
	end

endmodule
